@@ rtl/rc6_pkg.sv @@
// ----------------------------------------------------------------------------
// rc6_pkg
// Shared constants, codes and rotate helpers for the rc6 block cipher.
// ----------------------------------------------------------------------------
package rc6_pkg;

  localparam int ROUNDS_DEF    = 20;
  localparam int KEY_WORDS_DEF = 4;
  localparam int CFG_IW        = 3;

  localparam logic [31:0] P32 = 32'hB7E15163;
  localparam logic [31:0] Q32 = 32'h9E3779B9;

  localparam logic [1:0] FN_KEY = 2'd0;
  localparam logic [1:0] FN_ENC = 2'd1;
  localparam logic [1:0] FN_DEC = 2'd2;

  localparam logic [CFG_IW-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IW-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IW-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IW-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CBC  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_KINIT, S_KMIX, S_PRE, S_RMUL, S_RADD, S_POST, S_EMIT
  } state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

endpackage

@@ rtl/rc6_keymem.sv @@
// ----------------------------------------------------------------------------
// rc6_keymem
// Round key store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rc6_keymem #(
  parameter int DEPTH = 44,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/rc6_block_cipher.sv @@
// block item: accepted in idle, result registered in S_POST once output is free
// no item taken until back in idle; each round is a multiply step and an add step
// key setup: a fill sweep of 2*ROUNDS+4 words, then 3*(2*ROUNDS+4) mixing steps
// through the single key store write port
// synchronous reset clears config, chaining vector, key-loaded flag and control
// ----------------------------------------------------------------------------
// rc6_block_cipher
// Iterative rc6 encrypt/decrypt with key expansion and optional cbc chaining.
// ----------------------------------------------------------------------------
module rc6_block_cipher #(
  parameter int ROUNDS    = rc6_pkg::ROUNDS_DEF,
  parameter int KEY_WORDS = rc6_pkg::KEY_WORDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [1:0]                func,
  input  logic [31:0]               word_0,
  input  logic [31:0]               word_1,
  input  logic [31:0]               word_2,
  input  logic [31:0]               word_3,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [31:0]               out_0,
  output logic [31:0]               out_1,
  output logic [31:0]               out_2,
  output logic [31:0]               out_3,
  output logic                      status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rc6_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]               cfg_data
);
  import rc6_pkg::*;

  localparam int NUM_RK    = 2 * ROUNDS + 4;
  localparam int AW        = $clog2(NUM_RK);
  localparam int RW        = $clog2(ROUNDS + 1);
  localparam int JW        = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int MIX_STEPS = 3 * ((NUM_RK > KEY_WORDS) ? NUM_RK : KEY_WORDS);
  localparam int VW        = $clog2(MIX_STEPS);

  state_t state, state_next;

  logic [31:0]   key_cfg [4];
  logic          cbc_cfg;
  logic [31:0]   chain [4];
  logic [31:0]   saved [4];
  logic [31:0]   l_words [KEY_WORDS];
  logic          key_loaded;
  logic [31:0]   wa, wb, wc, wd, pb, pd, sv;
  logic [AW-1:0] kcnt;
  logic [JW-1:0] j;
  logic [VW-1:0] v;
  logic [RW-1:0] rnd, rnd_next;
  logic          dec_op, cbc_op, stat;

  logic          we;
  logic [AW-1:0] waddr, rd_a, rd_b;
  logic [31:0]   wdata, rk_a, rk_b;
  logic          accept, free, last_rnd;
  logic [31:0]   t, u, x0, x1;
  logic [31:0]   mix_an, mix_ab, mix_bn;
  logic [31:0]   enc_an, enc_cn, dec_an, dec_cn;
  logic [31:0]   fa, fb, fc, fd;
  logic [AW-1:0] kcnt_wrap;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && !item_stall;
  assign free       = !result_valid || !result_stall;

  rc6_keymem #(.DEPTH(NUM_RK), .AW(AW)) u_keymem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(rd_a), .raddr_b(rd_b), .rdata_a(rk_a), .rdata_b(rk_b)
  );

  always_comb begin
    t        = rotl32(pb, 5'd5);
    u        = rotl32(pd, 5'd5);
    x0       = dec_op ? wa : wb;
    x1       = dec_op ? wc : wd;
    enc_an   = rotl32(wa ^ t, u[4:0]) + rk_a;
    enc_cn   = rotl32(wc ^ u, t[4:0]) + rk_b;
    dec_cn   = rotr32(wb - rk_b, t[4:0]) ^ u;
    dec_an   = rotr32(wd - rk_a, u[4:0]) ^ t;
    mix_an   = rotl32(rk_a + wa + wb, 5'd3);
    mix_ab   = mix_an + wb;
    mix_bn   = rotl32(l_words[j] + mix_ab, mix_ab[4:0]);
    last_rnd = dec_op ? (rnd == RW'(1)) : (rnd == RW'(ROUNDS));
    rnd_next = dec_op ? (rnd - RW'(1)) : (rnd + RW'(1));
    kcnt_wrap = (kcnt == AW'(NUM_RK - 1)) ? '0 : (kcnt + AW'(1));
    if (dec_op) begin
      fa = wa; fb = wb - rk_a; fc = wc; fd = wd - rk_b;
      if (cbc_op) begin
        fa = fa ^ chain[0]; fb = fb ^ chain[1];
        fc = fc ^ chain[2]; fd = fd ^ chain[3];
      end
    end else begin
      fa = wa + rk_a; fb = wb; fc = wc + rk_b; fd = wd;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = kcnt;
    wdata      = sv;
    rd_a       = '0;
    rd_b       = '0;
    unique case (state)
      S_IDLE: begin
        rd_a = (func == FN_DEC) ? AW'(2 * ROUNDS + 2) : '0;
        rd_b = (func == FN_DEC) ? AW'(2 * ROUNDS + 3) : AW'(1);
        if (accept) begin
          if (func == FN_KEY) begin
            state_next = S_KINIT;
          end else if ((func == FN_ENC || func == FN_DEC) && key_loaded) begin
            state_next = S_PRE;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_KINIT: begin
        we = 1'b1;
        if (kcnt == AW'(NUM_RK - 1)) begin
          state_next = S_KMIX;
        end
      end
      S_KMIX: begin
        we    = 1'b1;
        wdata = mix_an;
        rd_a  = kcnt_wrap;
        if (v == VW'(MIX_STEPS - 1)) begin
          state_next = S_EMIT;
        end
      end
      S_PRE, S_RMUL: begin
        rd_a = AW'({rnd, 1'b0});
        rd_b = AW'({rnd, 1'b1});
        if (state == S_PRE) begin
          state_next = S_RMUL;
        end else begin
          state_next = S_RADD;
        end
      end
      S_RADD: begin
        if (last_rnd) begin
          rd_a = dec_op ? '0 : AW'(2 * ROUNDS + 2);
          rd_b = dec_op ? AW'(1) : AW'(2 * ROUNDS + 3);
          state_next = S_POST;
        end else begin
          rd_a = AW'({rnd_next, 1'b0});
          rd_b = AW'({rnd_next, 1'b1});
          state_next = S_RMUL;
        end
      end
      S_POST: begin
        rd_a = dec_op ? '0 : AW'(2 * ROUNDS + 2);
        rd_b = dec_op ? AW'(1) : AW'(2 * ROUNDS + 3);
        if (free) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      key_loaded   <= 1'b0;
      cbc_cfg      <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        key_cfg[k] <= '0;
        chain[k]   <= '0;
      end
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY0: key_cfg[0] <= cfg_data;
          REG_KEY1: key_cfg[1] <= cfg_data;
          REG_KEY2: key_cfg[2] <= cfg_data;
          REG_KEY3: key_cfg[3] <= cfg_data;
          REG_CBC:  cbc_cfg    <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            dec_op <= (func == FN_DEC);
            cbc_op <= cbc_cfg;
            stat   <= (func == FN_ENC || func == FN_DEC) && !key_loaded;
            rnd    <= (func == FN_DEC) ? RW'(ROUNDS) : RW'(1);
            kcnt   <= '0;
            sv     <= P32;
            saved[0] <= word_0; saved[1] <= word_1;
            saved[2] <= word_2; saved[3] <= word_3;
            for (int k = 0; k < KEY_WORDS; k++) begin
              l_words[k] <= key_cfg[k];
            end
            if (func == FN_KEY) begin
              wa <= '0; wb <= '0;
            end else if (func == FN_ENC && cbc_cfg) begin
              wa <= word_0 ^ chain[0]; wb <= word_1 ^ chain[1];
              wc <= word_2 ^ chain[2]; wd <= word_3 ^ chain[3];
            end else begin
              wa <= word_0; wb <= word_1; wc <= word_2; wd <= word_3;
            end
          end
        end
        S_KINIT: begin
          sv   <= sv + Q32;
          kcnt <= kcnt_wrap;
          j    <= '0;
          v    <= '0;
        end
        S_KMIX: begin
          wa         <= mix_an;
          wb         <= mix_bn;
          l_words[j] <= mix_bn;
          kcnt       <= kcnt_wrap;
          j          <= (j == JW'(KEY_WORDS - 1)) ? '0 : (j + JW'(1));
          v          <= v + VW'(1);
          if (v == VW'(MIX_STEPS - 1)) begin
            key_loaded <= 1'b1;
            stat       <= 1'b0;
            for (int k = 0; k < 4; k++) begin
              chain[k] <= '0;
            end
          end
        end
        S_PRE: begin
          if (dec_op) begin
            wa <= wa - rk_a; wc <= wc - rk_b;
          end else begin
            wb <= wb + rk_a; wd <= wd + rk_b;
          end
        end
        S_RMUL: begin
          pb <= x0 * {x0[30:0], 1'b1};
          pd <= x1 * {x1[30:0], 1'b1};
        end
        S_RADD: begin
          rnd <= rnd_next;
          if (dec_op) begin
            wa <= dec_an; wb <= wa; wc <= dec_cn; wd <= wc;
          end else begin
            wa <= wb; wb <= enc_cn; wc <= wd; wd <= enc_an;
          end
        end
        S_POST: begin
          if (free) begin
            result_valid <= 1'b1;
            out_0 <= fa; out_1 <= fb; out_2 <= fc; out_3 <= fd;
            status <= 1'b0;
            if (cbc_op) begin
              if (dec_op) begin
                for (int k = 0; k < 4; k++) begin
                  chain[k] <= saved[k];
                end
              end else begin
                chain[0] <= fa; chain[1] <= fb; chain[2] <= fc; chain[3] <= fd;
              end
            end
          end
        end
        S_EMIT: begin
          if (free) begin
            result_valid <= 1'b1;
            out_0 <= '0; out_1 <= '0; out_2 <= '0; out_3 <= '0;
            status <= stat;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/rc6_checker.sv @@
// ----------------------------------------------------------------------------
// rc6_port_checks
// Port-level checks for the rc6 block cipher, bound to the top level.
// ----------------------------------------------------------------------------
module rc6_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] out_0,
  input logic [31:0] out_1,
  input logic [31:0] out_2,
  input logic [31:0] out_3,
  input logic        status
);

  // held result keeps its valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // held result keeps its first data word and its status
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(out_0) && $stable(status))
    else $error("result changed while stalled");

  // busy right after a transaction is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("new item taken during work");

  // refused block carries an all-zero block
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> out_0 == '0 && out_1 == '0 && out_2 == '0 && out_3 == '0)
    else $error("refused result not zero");

endmodule

bind rc6_block_cipher rc6_port_checks u_rc6_checker (.*);

@@ tb/sv/rc6_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc6_checker
// Watches the item, result and register write channels of the rc6 cipher.
// Predicts each result from its own copy of the key schedule, chaining vector
// and register settings, then compares results in order, field by field.
// ----------------------------------------------------------------------------
module rc6_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_stall,
  input  logic [1:0]                 func,
  input  logic [31:0]                word_0,
  input  logic [31:0]                word_1,
  input  logic [31:0]                word_2,
  input  logic [31:0]                word_3,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  logic [31:0]                out_0,
  input  logic [31:0]                out_1,
  input  logic [31:0]                out_2,
  input  logic [31:0]                out_3,
  input  logic                       status,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [rc6_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                cfg_data,
  output int                         fail_count,
  output int                         pending_count
);
  import rc6_pkg::*;

  localparam int NR = 20;
  localparam int NK = 2 * NR + 4;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic        st;
  } cipher_out_t;

  cipher_out_t expected_blocks[$];
  logic [31:0] sched[NK];
  logic [31:0] chain[4];
  logic [31:0] key_reg[4];
  logic        cbc_on;
  logic        keyed;

  function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [4:0] n);
    return (x << n) | (x >> (6'd32 - n));
  endfunction

  function automatic logic [31:0] rot_right(input logic [31:0] x, input logic [4:0] n);
    return (x >> n) | (x << (6'd32 - n));
  endfunction

  function automatic logic [31:0] quad_mix(input logic [31:0] x);
    logic [31:0] p;
    p = x * {x[30:0], 1'b1};
    return rot_left(p, 5'd5);
  endfunction

  function automatic void expand_schedule();
    logic [31:0] lw[4];
    logic [31:0] a, b, s;
    int i, j;
    a = 0;
    b = 0;
    i = 0;
    j = 0;
    for (int k = 0; k < 4; k++) lw[k] = key_reg[k];
    sched[0] = P32;
    for (int k = 1; k < NK; k++) sched[k] = sched[k-1] + Q32;
    for (int v = 0; v < 3 * NK; v++) begin
      sched[i] = rot_left(sched[i] + a + b, 5'd3);
      a = sched[i];
      s = a + b;
      lw[j] = rot_left(lw[j] + s, s[4:0]);
      b = lw[j];
      i = (i + 1) % NK;
      j = (j + 1) % 4;
    end
    for (int k = 0; k < 4; k++) chain[k] = 0;
    keyed = 1'b1;
  endfunction

  function automatic void encipher(inout logic [31:0] w[4]);
    logic [31:0] a, b, c, d, t, u, tmp;
    a = w[0];
    b = w[1] + sched[0];
    c = w[2];
    d = w[3] + sched[1];
    for (int r = 1; r <= NR; r++) begin
      t = quad_mix(b);
      u = quad_mix(d);
      a = rot_left(a ^ t, u[4:0]) + sched[2*r];
      c = rot_left(c ^ u, t[4:0]) + sched[2*r+1];
      tmp = a; a = b; b = c; c = d; d = tmp;
    end
    w[0] = a + sched[2*NR+2];
    w[1] = b;
    w[2] = c + sched[2*NR+3];
    w[3] = d;
  endfunction

  function automatic void decipher(inout logic [31:0] w[4]);
    logic [31:0] a, b, c, d, t, u, tmp;
    a = w[0] - sched[2*NR+2];
    b = w[1];
    c = w[2] - sched[2*NR+3];
    d = w[3];
    for (int r = NR; r >= 1; r--) begin
      tmp = d; d = c; c = b; b = a; a = tmp;
      u = quad_mix(d);
      t = quad_mix(b);
      c = rot_right(c - sched[2*r+1], t[4:0]) ^ u;
      a = rot_right(a - sched[2*r], u[4:0]) ^ t;
    end
    w[0] = a;
    w[1] = b - sched[0];
    w[2] = c;
    w[3] = d - sched[1];
  endfunction

  function automatic cipher_out_t predict_block(input logic [1:0] fn,
                                                input logic [31:0] blk[4]);
    cipher_out_t res;
    logic [31:0] w[4];
    res = '0;
    w = blk;
    if (fn == FN_KEY) begin
      expand_schedule();
    end else if (fn == FN_ENC || fn == FN_DEC) begin
      if (!keyed) begin
        res.st = 1'b1;
      end else begin
        if (fn == FN_ENC) begin
          if (cbc_on) for (int k = 0; k < 4; k++) w[k] ^= chain[k];
          encipher(w);
          if (cbc_on) chain = w;
        end else begin
          decipher(w);
          if (cbc_on) begin
            for (int k = 0; k < 4; k++) w[k] ^= chain[k];
            chain = blk;
          end
        end
        res.w0 = w[0];
        res.w1 = w[1];
        res.w2 = w[2];
        res.w3 = w[3];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cipher_out_t exp_res, act;
    logic [31:0] blk[4];
    if (rst) begin
      expected_blocks.delete();
      for (int k = 0; k < 4; k++) begin
        key_reg[k] = 0;
        chain[k] = 0;
      end
      cbc_on = 0;
      keyed = 0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY0: key_reg[0] = cfg_data;
          REG_KEY1: key_reg[1] = cfg_data;
          REG_KEY2: key_reg[2] = cfg_data;
          REG_KEY3: key_reg[3] = cfg_data;
          REG_CBC:  cbc_on = cfg_data[0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        act = '{out_0, out_1, out_2, out_3, status};
        if (expected_blocks.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: %h %h %h %h st=%b",
                     out_0, out_1, out_2, out_3, status);
        end else begin
          exp_res = expected_blocks.pop_front();
          if (act !== exp_res) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp %h %h %h %h st=%b, got %h %h %h %h st=%b",
                       exp_res.w0, exp_res.w1, exp_res.w2, exp_res.w3, exp_res.st,
                       act.w0, act.w1, act.w2, act.w3, act.st);
          end
        end
      end
      if (item_valid && !item_stall) begin
        blk = '{word_0, word_1, word_2, word_3};
        expected_blocks.push_back(predict_block(func, blk));
      end
    end
    pending_count = expected_blocks.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the rc6 cipher: directed corner blocks, then register phases
// with varied keys and chaining, and random traffic with idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import rc6_pkg::*;

  localparam logic [1:0] FN_NONE = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_stall;
  logic [1:0] func = FN_KEY;
  logic [31:0] word_0 = 0, word_1 = 0, word_2 = 0, word_3 = 0;
  logic result_valid;
  logic result_stall = 0;
  logic [31:0] out_0, out_1, out_2, out_3;
  logic status;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = REG_KEY0;
  logic [31:0] cfg_data = 0;
  int fail_count, pending_count;
  bit quiet = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  rc6_block_cipher u_dut (.*);

  rc6_checker u_chk (.*);

  always @(negedge clk) result_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 27);

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(input logic [1:0] fn, input logic [31:0] a, b, c, d);
    while (!quiet && $urandom_range(0, 99) < 27) begin
      item_valid = 0;
      @(negedge clk);
    end
    func = fn;
    word_0 = a;
    word_1 = b;
    word_2 = c;
    word_3 = d;
    item_valid = 1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    item_valid = 0;
  endtask

  task automatic drain();
    wait (pending_count == 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_key(input logic [31:0] k0, k1, k2, k3, input logic cbc);
    drain();
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    write_reg(REG_CBC, {31'b0, cbc});
  endtask

  task automatic random_traffic(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_block(FN_KEY, $urandom, $urandom, $urandom, $urandom);
      else if (r < 4) send_block(FN_NONE, $urandom, $urandom, $urandom, $urandom);
      else if (r < 52) send_block(FN_ENC, pick_word(), pick_word(), pick_word(), pick_word());
      else send_block(FN_DEC, pick_word(), pick_word(), pick_word(), pick_word());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // enc/dec blocks before any key setup are refused; an unknown function follows
    send_block(FN_ENC, 32'h0, 32'h0, 32'h0, 32'h0);
    send_block(FN_DEC, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_block(FN_NONE, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0);

    set_key(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_block(FN_KEY, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_block(FN_ENC, 32'h0, 32'h0, 32'h0, 32'h0);
    send_block(FN_ENC, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_block(FN_DEC, 32'h0, 32'h0, 32'h0, 32'h0);
    send_block(FN_DEC, 32'hFFFFFFFF, 32'h80000000, 32'h00000001, 32'h7FFFFFFF);
    send_block(FN_NONE, 32'h0, 32'h0, 32'h0, 32'h0);

    set_key(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    send_block(FN_KEY, 32'h0, 32'h0, 32'h0, 32'h0);
    send_block(FN_ENC, 32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210);
    send_block(FN_ENC, 32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210);
    send_block(FN_KEY, 32'h0, 32'h0, 32'h0, 32'h0);
    send_block(FN_DEC, 32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
    send_block(FN_DEC, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0);

    for (int ph = 0; ph < 8; ph++) begin
      set_key($urandom, $urandom, $urandom, $urandom, ph[0]);
      send_block(FN_KEY, $urandom, $urandom, $urandom, $urandom);
      quiet = (ph == 3);
      random_traffic(80);
      if (ph == 5) begin
        wait (pending_count == 0);
        @(negedge clk);
      end
      random_traffic(80);
      quiet = 0;
    end

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
